>>> hdl/trlsa_pkg.sv
// Package for the timed-release lowest-slot allocator.
// Field widths, register map codes and reset values; no dependencies.
`default_nettype none

package trlsa_pkg;

  // default sizing handed to the top level parameters
  localparam int MAX_SLOTS_DEF = 64;
  localparam int TIME_BITS_DEF = 32;

  // fixed field widths
  localparam int REQ_W   = 6;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;
  localparam int CFG_DW  = 32;
  localparam int CFG_AW  = 3;

  // register index codes (paddr[2])
  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_TARGET     = 1'b1;

  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 7'd64;
  localparam logic [REQ_W-1:0]   TARGET_RST     = 6'd0;

endpackage

`default_nettype wire

>>> hdl/trlsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the per-slot leave times.
`default_nettype none

module trlsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/timed_release_lowest_slot_allocator_unit.sv
// Top level of the timed-release lowest-slot allocator.
// Uses trlsa_pkg and trlsa_ram (leave-time store).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in_     | slave     | tvalid/tready       | tdata: arrival_time, leave_time, requester
//  out_    | master    | tvalid/tready       | tdata: granted_slot; tuser: none_free, is_target
//  cfg_    | APB slave | psel/penable/pready | slot_count @0x0, target_requester @0x4
//
// Flow: a request is accepted in IDLE, then the scan walks the leave-time RAM one
// slot per cycle through its single read port, then the FIN state commits the grant.
// A new request is taken only in IDLE, so not before the previous one has committed.
// Reset: synchronous active-low rst_n; all slots free, slot_count 64, target 0.
// Stalls: the result sits in an output register; the commit cycle waits only if the
// previous result was not yet taken.
`default_nettype none

module timed_release_lowest_slot_allocator_unit
  import trlsa_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  localparam int IN_W = ((2 * TIME_BITS + REQ_W + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input requests
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_W-1:0]   in_tdata,   // arrival_time, leave_time, requester_index, 0 pad
  // results
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,  // granted_slot[5:0], 2'b0 pad
  output logic [1:0]             out_tuser,  // none_free, is_target
  // configuration
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int IW = $clog2(MAX_SLOTS);          // slot index width
  localparam int CW = $clog2(MAX_SLOTS + 1);      // scan counter, holds MAX_SLOTS
  localparam int LW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W; // compare width vs count

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // config registers
  logic [COUNT_W-1:0]   slot_count_r, slot_count_nxt;
  logic [REQ_W-1:0]     target_r, target_nxt;
  logic                 cfg_wr;

  // control
  logic [1:0]           state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 ev_valid_r, ev_valid_nxt;
  logic [IW-1:0]        ev_idx_r, ev_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IW-1:0]        granted_r, granted_nxt;
  logic [MAX_SLOTS-1:0] busy_r, busy_nxt;

  // request payload held over the scan
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] leave_r, leave_nxt;
  logic                 hit_r, hit_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic                 out_none_r, out_none_nxt;
  logic                 out_hit_r, out_hit_nxt;

  // datapath
  logic                 in_acc;
  logic                 fin_go;
  logic                 ram_we;
  logic [TIME_BITS-1:0] ram_rdata;
  logic                 slot_busy;
  logic                 slot_expired;
  logic                 slot_free;
  logic                 slot_in_range;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign ram_we    = fin_go && found_r;

  // the one shared compare: stored leave time against arrival time
  assign slot_busy     = busy_r[ev_idx_r];
  assign slot_expired  = (ram_rdata <= now_r);
  assign slot_free     = !slot_busy || slot_expired;
  assign slot_in_range = (LW'(ev_idx_r) < LW'(slot_count_r));

  trlsa_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_SLOTS)
  ) u_leave_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (granted_r),
    .wdata (leave_r),
    .raddr (cnt_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  // APB config: write on the access phase, read is combinational
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    slot_count_nxt = slot_count_r;
    target_nxt     = target_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SLOT_COUNT: slot_count_nxt = cfg_pwdata[COUNT_W-1:0];
        REG_TARGET:     target_nxt     = cfg_pwdata[REQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_SLOT_COUNT: cfg_prdata = CFG_DW'(slot_count_r);
      REG_TARGET:     cfg_prdata = CFG_DW'(target_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ev_valid_nxt  = 1'b0;
    ev_idx_nxt    = cnt_r[IW-1:0];
    found_nxt     = found_r;
    granted_nxt   = granted_r;
    busy_nxt      = busy_r;
    now_nxt       = now_r;
    leave_nxt     = leave_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    out_slot_nxt  = out_slot_r;
    out_none_nxt  = out_none_r;
    out_hit_nxt   = out_hit_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          now_nxt     = in_tdata[TIME_BITS-1:0];
          leave_nxt   = in_tdata[2*TIME_BITS-1:TIME_BITS];
          hit_nxt     = (in_tdata[2*TIME_BITS +: REQ_W] == target_r);
          cnt_nxt     = '0;
          found_nxt   = 1'b0;
          granted_nxt = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, evaluate the slot read last cycle
        if (cnt_r != CW'(MAX_SLOTS)) begin
          ev_valid_nxt = 1'b1;
          cnt_nxt      = cnt_r + CW'(1);
        end else begin
          state_nxt = ST_FIN;
        end
        if (ev_valid_r) begin
          if (slot_busy && slot_expired) begin
            busy_nxt[ev_idx_r] = 1'b0;
          end
          if (slot_free && slot_in_range && !found_r) begin
            found_nxt   = 1'b1;
            granted_nxt = ev_idx_r;
          end
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          if (found_r) begin
            busy_nxt[granted_r] = 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_slot_nxt  = found_r ? SLOT_W'(granted_r) : '0;
          out_none_nxt  = !found_r;
          out_hit_nxt   = hit_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= SLOT_COUNT_RST;
      target_r     <= TARGET_RST;
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      ev_valid_r   <= 1'b0;
      found_r      <= 1'b0;
      busy_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      slot_count_r <= slot_count_nxt;
      target_r     <= target_nxt;
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      ev_valid_r   <= ev_valid_nxt;
      found_r      <= found_nxt;
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r   <= ev_idx_nxt;
    granted_r  <= granted_nxt;
    now_r      <= now_nxt;
    leave_r    <= leave_nxt;
    hit_r      <= hit_nxt;
    out_slot_r <= out_slot_nxt;
    out_none_r <= out_none_nxt;
    out_hit_r  <= out_hit_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_slot_r};
  assign out_tuser  = {out_hit_r, out_none_r};

`ifndef SYNTH
  // an accepted request always starts a scan
  a_acc_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN))
    else $error("request accepted but scan did not start");

  // a grant leaves its slot busy
  a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && found_r) |=> busy_r[$past(granted_r)])
    else $error("granted slot not marked busy");

  // a granted slot lies below the configured count
  a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_none_r) |-> (LW'(out_slot_r) < LW'(slot_count_r)))
    else $error("granted slot beyond slot count");

  // no evaluation in flight while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ev_valid_r)
    else $error("slot evaluation pending in idle");
`endif

endmodule

`default_nettype wire
